[src/gchg_pkg.sv]
package gchg_pkg;

	localparam int DATA_W          = 32;
	localparam int OP_W            = 2;
	localparam int MAX_DENOMS_DEF  = 32;

	localparam logic [OP_W-1:0] OP_APPEND   = 2'd0;
	localparam logic [OP_W-1:0] OP_WITHDRAW = 2'd1;
	localparam logic [OP_W-1:0] OP_CLEAR    = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SORT_RDI,
		ST_SORT_LDI,
		ST_SORT_RDJ,
		ST_SORT_CMP,
		ST_SWAP_A,
		ST_SWAP_B,
		ST_DIV_RD,
		ST_DIV_CHK,
		ST_DIV_WAIT,
		ST_OUT_RD,
		ST_OUT_LD,
		ST_OUT_WAIT
	} state_t;

	typedef struct packed {
		logic              done;
		logic [DATA_W-1:0] quot;
		logic [DATA_W-1:0] rem;
	} div_res_t;

endpackage

[src/greedy_change_dispenser_unit.sv]
// greedy change dispenser
// input channel (in_valid/in_ready) takes one item: op, denom_value, amount.
// op append stores a nonzero note value into the table (dropped when full),
// op clear empties the table, op withdraw pays out amount greedily.
// a withdraw produces one output item per stored denomination, largest first,
// with note_count, the final remainder, exact and last on the final item;
// an empty table gives a single item with zero denomination and count.
// append and clear complete in the idle state. a withdraw first runs a selection
// sort of the table, largest first, then per denomination a division on the
// shared 32-step restoring divider (skipped when the remaining amount is below
// the denomination), then emits the output items.
// in_ready is low from the accepted withdraw until its last item is taken.
// when out_ready is low the output item holds and the sequencer waits.
// reset clears the table fill count and the control state; table contents
// are not cleared, only entries below the fill count are ever read.
module greedy_change_dispenser_unit #(
	parameter int MAX_DENOMS = gchg_pkg::MAX_DENOMS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [gchg_pkg::OP_W-1:0]     op,
	input  logic [gchg_pkg::DATA_W-1:0]   denom_value,
	input  logic [gchg_pkg::DATA_W-1:0]   amount,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [gchg_pkg::DATA_W-1:0]   denomination,
	output logic [gchg_pkg::DATA_W-1:0]   note_count,
	output logic [gchg_pkg::DATA_W-1:0]   remainder,
	output logic                          exact,
	output logic                          last
);
	import gchg_pkg::*;

	localparam int CW = $clog2(MAX_DENOMS + 1);
	localparam int IW = (MAX_DENOMS > 1) ? $clog2(MAX_DENOMS) : 1;

	state_t state_q, state_d;

	logic [DATA_W-1:0] tbl_mem [MAX_DENOMS];
	logic [DATA_W-1:0] cnt_mem [MAX_DENOMS];
	logic [DATA_W-1:0] trd_q;
	logic [DATA_W-1:0] crd_q;

	logic [CW-1:0]     count_q;
	logic [CW-1:0]     i_q;
	logic [CW-1:0]     j_q;
	logic [CW-1:0]     best_idx_q;
	logic [DATA_W-1:0] val_i_q;
	logic [DATA_W-1:0] best_q;
	logic [DATA_W-1:0] rest_q;

	logic [DATA_W-1:0] den_q;
	logic [DATA_W-1:0] ncnt_q;
	logic [DATA_W-1:0] rem_out_q;
	logic              exact_q;
	logic              last_q;

	logic              tbl_we;
	logic [IW-1:0]     tbl_waddr;
	logic [DATA_W-1:0] tbl_wdata;
	logic [IW-1:0]     rd_addr;
	logic              cnt_we;
	logic [DATA_W-1:0] cnt_wdata;
	logic              div_start;
	div_res_t          div_res;

	logic              in_acc;
	logic              do_append;
	logic [CW:0]       cnt_ext;
	logic [CW:0]       i_inc;
	logic [CW:0]       i_inc2;
	logic [CW:0]       j_inc;
	logic              skip_div;

	assign in_acc    = in_valid && in_ready;
	assign do_append = in_acc && (op == OP_APPEND) && (denom_value != '0)
		&& (count_q < CW'(MAX_DENOMS));
	assign cnt_ext   = {1'b0, count_q};
	assign i_inc     = {1'b0, i_q} + (CW+1)'(1);
	assign i_inc2    = {1'b0, i_q} + (CW+1)'(2);
	assign j_inc     = {1'b0, j_q} + (CW+1)'(1);
	assign skip_div  = (trd_q == '0) || (rest_q < trd_q);

	gchg_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (rest_q),
		.divisor  (trd_q),
		.res      (div_res)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && op == OP_WITHDRAW) begin
					if (count_q == '0)
						state_d = ST_OUT_WAIT;
					else if (count_q == CW'(1))
						state_d = ST_DIV_RD;
					else
						state_d = ST_SORT_RDI;
				end
			end
			ST_SORT_RDI: state_d = ST_SORT_LDI;
			ST_SORT_LDI: state_d = ST_SORT_RDJ;
			ST_SORT_RDJ: state_d = ST_SORT_CMP;
			ST_SORT_CMP: begin
				if (j_inc == cnt_ext)
					state_d = ST_SWAP_A;
				else
					state_d = ST_SORT_RDJ;
			end
			ST_SWAP_A: state_d = ST_SWAP_B;
			ST_SWAP_B: begin
				if (i_inc2 == cnt_ext)
					state_d = ST_DIV_RD;
				else
					state_d = ST_SORT_RDI;
			end
			ST_DIV_RD: state_d = ST_DIV_CHK;
			ST_DIV_CHK: begin
				if (skip_div)
					state_d = (i_inc == cnt_ext) ? ST_OUT_RD : ST_DIV_RD;
				else
					state_d = ST_DIV_WAIT;
			end
			ST_DIV_WAIT: begin
				if (div_res.done)
					state_d = (i_inc == cnt_ext) ? ST_OUT_RD : ST_DIV_RD;
			end
			ST_OUT_RD: state_d = ST_OUT_LD;
			ST_OUT_LD: state_d = ST_OUT_WAIT;
			ST_OUT_WAIT: begin
				if (out_ready)
					state_d = last_q ? ST_IDLE : ST_OUT_RD;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		in_ready  = 1'b0;
		out_valid = 1'b0;
		tbl_we    = 1'b0;
		tbl_waddr = i_q[IW-1:0];
		tbl_wdata = best_q;
		rd_addr   = i_q[IW-1:0];
		cnt_we    = 1'b0;
		cnt_wdata = div_res.quot;
		div_start = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready  = 1'b1;
				tbl_we    = do_append;
				tbl_waddr = count_q[IW-1:0];
				tbl_wdata = denom_value;
			end
			ST_SORT_RDJ: rd_addr = j_q[IW-1:0];
			ST_SWAP_A: begin
				tbl_we    = 1'b1;
				tbl_waddr = best_idx_q[IW-1:0];
				tbl_wdata = val_i_q;
			end
			ST_SWAP_B: tbl_we = 1'b1;
			ST_DIV_CHK: begin
				div_start = !skip_div;
				cnt_we    = skip_div;
				cnt_wdata = '0;
			end
			ST_DIV_WAIT: cnt_we = div_res.done;
			ST_OUT_WAIT: out_valid = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			if (do_append)
				count_q <= count_q + CW'(1);
			else if (in_acc && op == OP_CLEAR)
				count_q <= '0;
		end
	end

	// table and count memories
	always_ff @(posedge clk) begin
		if (tbl_we)
			tbl_mem[tbl_waddr] <= tbl_wdata;
		if (cnt_we)
			cnt_mem[i_q[IW-1:0]] <= cnt_wdata;
		trd_q <= tbl_mem[rd_addr];
		crd_q <= cnt_mem[rd_addr];
	end

	// sequencer datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				i_q       <= '0;
				rest_q    <= amount;
				den_q     <= '0;
				ncnt_q    <= '0;
				rem_out_q <= amount;
				exact_q   <= (amount == '0);
				last_q    <= 1'b1;
			end
			ST_SORT_LDI: begin
				val_i_q    <= trd_q;
				best_q     <= trd_q;
				best_idx_q <= i_q;
				j_q        <= i_inc[CW-1:0];
			end
			ST_SORT_CMP: begin
				if (trd_q > best_q) begin
					best_q     <= trd_q;
					best_idx_q <= j_q;
				end
				j_q <= j_inc[CW-1:0];
			end
			ST_SWAP_B: begin
				if (i_inc2 == cnt_ext)
					i_q <= '0;
				else
					i_q <= i_inc[CW-1:0];
			end
			ST_DIV_CHK: begin
				if (skip_div)
					i_q <= (i_inc == cnt_ext) ? '0 : i_inc[CW-1:0];
			end
			ST_DIV_WAIT: begin
				if (div_res.done) begin
					rest_q <= div_res.rem;
					i_q    <= (i_inc == cnt_ext) ? '0 : i_inc[CW-1:0];
				end
			end
			ST_OUT_LD: begin
				den_q     <= trd_q;
				ncnt_q    <= crd_q;
				rem_out_q <= rest_q;
				exact_q   <= (rest_q == '0);
				last_q    <= (i_inc == cnt_ext);
			end
			ST_OUT_WAIT: begin
				if (out_ready)
					i_q <= i_inc[CW-1:0];
			end
			default: ;
		endcase
	end

	assign denomination = den_q;
	assign note_count   = ncnt_q;
	assign remainder    = rem_out_q;
	assign exact        = exact_q;
	assign last         = last_q;

endmodule

[src/gchg_div.sv]
module gchg_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [gchg_pkg::DATA_W-1:0]   dividend,
	input  logic [gchg_pkg::DATA_W-1:0]   divisor,
	output gchg_pkg::div_res_t            res
);
	import gchg_pkg::*;

	localparam int CNT_W = $clog2(DATA_W + 1);

	logic [DATA_W-1:0] quo_q;
	logic [DATA_W-1:0] rem_q;
	logic [DATA_W-1:0] dvs_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [DATA_W:0]   r_shift;
	logic [DATA_W:0]   diff;

	// one quotient bit per cycle, restoring
	assign r_shift = {rem_q, quo_q[DATA_W-1]};
	assign diff    = r_shift - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CNT_W'(DATA_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!diff[DATA_W]) begin
				rem_q <= diff[DATA_W-1:0];
				quo_q <= {quo_q[DATA_W-2:0], 1'b1};
			end else begin
				rem_q <= r_shift[DATA_W-1:0];
				quo_q <= {quo_q[DATA_W-2:0], 1'b0};
			end
		end
	end

	assign res.done = done_q;
	assign res.quot = quo_q;
	assign res.rem  = rem_q;

endmodule

[dv/greedy_change_dispenser_unit_test.sv]
module greedy_change_dispenser_unit_test;
	import gchg_pkg::*;

	localparam int NOTES        = MAX_DENOMS_DEF;
	localparam int ITEM_TARGET  = 420;
	localparam int CYCLE_LIMIT  = 5_000_000;
	localparam int DRAIN_CYCLES = 200;
	localparam int MAX_REPORTS  = 10;

	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	typedef struct packed {
		logic [DATA_W-1:0] denom;
		logic [DATA_W-1:0] count;
		logic [DATA_W-1:0] rem;
		logic              exact;
		logic              last;
	} payout_t;

	// fixed marks a row whose single payout item is typed in by hand
	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [DATA_W-1:0] dv;
		logic [DATA_W-1:0] amt;
		logic              fixed;
		logic [DATA_W-1:0] w_denom;
		logic [DATA_W-1:0] w_count;
		logic [DATA_W-1:0] w_rem;
		logic              w_exact;
		logic              w_last;
	} request_t;

	localparam request_t DIRECTED [25] = '{
		'{OP_WITHDRAW, 32'h0, 32'h0,         1'b1, 32'h0, 32'h0, 32'h0,         1'b1, 1'b1},
		'{OP_WITHDRAW, 32'h0, 32'hFFFF_FFFF, 1'b1, 32'h0, 32'h0, 32'hFFFF_FFFF, 1'b0, 1'b1},
		'{OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 32'h0, 32'h0, 32'h0,   1'b0, 1'b0},
		'{OP_APPEND,   32'h0, 32'h0,         1'b0, 32'h0, 32'h0, 32'h0,         1'b0, 1'b0},
		'{OP_WITHDRAW, 32'h0, 32'd5,         1'b1, 32'h0, 32'h0, 32'd5,         1'b0, 1'b1},
		'{OP_CLEAR,    32'h0, 32'h0,         1'b0, 32'h0, 32'h0, 32'h0,         1'b0, 1'b0},
		'{OP_APPEND,   32'd1, 32'h0,         1'b0, 32'h0, 32'h0, 32'h0,         1'b0, 1'b0},
		'{OP_WITHDRAW, 32'h0, 32'hFFFF_FFFF, 1'b1, 32'd1, 32'hFFFF_FFFF, 32'h0, 1'b1, 1'b1},
		'{OP_WITHDRAW, 32'h0, 32'h0,         1'b1, 32'd1, 32'h0, 32'h0,         1'b1, 1'b1},
		'{OP_APPEND,   32'hFFFF_FFFF, 32'h0, 1'b0, 32'h0, 32'h0, 32'h0,         1'b0, 1'b0},
		'{OP_APPEND,   32'd1, 32'h0,         1'b0, 32'h0, 32'h0, 32'h0,         1'b0, 1'b0},
		'{OP_WITHDRAW, 32'h0, 32'hFFFF_FFFE, 1'b0, 32'h0, 32'h0, 32'h0,         1'b0, 1'b0},
		'{OP_WITHDRAW, 32'h0, 32'hFFFF_FFFF, 1'b0, 32'h0, 32'h0, 32'h0,         1'b0, 1'b0},
		'{OP_CLEAR,    32'h0, 32'h0,         1'b0, 32'h0, 32'h0, 32'h0,         1'b0, 1'b0},
		'{OP_WITHDRAW, 32'h0, 32'd7,         1'b1, 32'h0, 32'h0, 32'd7,         1'b0, 1'b1},
		'{OP_APPEND,   32'd7, 32'h0,         1'b0, 32'h0, 32'h0, 32'h0,         1'b0, 1'b0},
		'{OP_APPEND,   32'd3, 32'h0,         1'b0, 32'h0, 32'h0, 32'h0,         1'b0, 1'b0},
		'{OP_APPEND,   32'd5, 32'h0,         1'b0, 32'h0, 32'h0, 32'h0,         1'b0, 1'b0},
		'{OP_APPEND,   32'd3, 32'h0,         1'b0, 32'h0, 32'h0, 32'h0,         1'b0, 1'b0},
		'{OP_APPEND,   32'h8000_0000, 32'h0, 1'b0, 32'h0, 32'h0, 32'h0,         1'b0, 1'b0},
		'{OP_WITHDRAW, 32'h0, 32'd20,        1'b0, 32'h0, 32'h0, 32'h0,         1'b0, 1'b0},
		'{OP_WITHDRAW, 32'h0, 32'd2,         1'b0, 32'h0, 32'h0, 32'h0,         1'b0, 1'b0},
		'{OP_APPEND,   32'd2, 32'h0,         1'b0, 32'h0, 32'h0, 32'h0,         1'b0, 1'b0},
		'{OP_WITHDRAW, 32'h0, 32'd6,         1'b0, 32'h0, 32'h0, 32'h0,         1'b0, 1'b0},
		'{OP_CLEAR,    32'h0, 32'h0,         1'b0, 32'h0, 32'h0, 32'h0,         1'b0, 1'b0}
	};

	logic              clk         = 1'b0;
	logic              arst_n      = 1'b0;
	logic              in_valid    = 1'b0;
	logic              in_ready;
	logic [OP_W-1:0]   op          = OP_APPEND;
	logic [DATA_W-1:0] denom_value = '0;
	logic [DATA_W-1:0] amount      = '0;
	logic              out_valid;
	logic              out_ready   = 1'b0;
	logic [DATA_W-1:0] denomination;
	logic [DATA_W-1:0] note_count;
	logic [DATA_W-1:0] remainder;
	logic              exact;
	logic              last;

	greedy_change_dispenser_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.op           (op),
		.denom_value  (denom_value),
		.amount       (amount),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.denomination (denomination),
		.note_count   (note_count),
		.remainder    (remainder),
		.exact        (exact),
		.last         (last)
	);

	always #1 clk = ~clk;

	logic [DATA_W-1:0] note_tbl [NOTES];
	int                note_fill = 0;
	payout_t           payout_q [$];
	request_t          request_q [$];
	int                useful_cnt = 0;
	int                err_cnt    = 0;
	int                cycle_cnt  = 0;

	int send_idx   = 0;
	int next_idx;
	int burst_left = 0;
	int gap_left   = 0;
	int stall_left = 0;
	int rx_mode    = 0;
	int rx_epoch   = 0;

	payout_t got;
	payout_t want;

	task automatic predict_payout(input request_t rq);
		logic [DATA_W-1:0] rest;
		logic [DATA_W-1:0] tmp;
		logic [DATA_W-1:0] cnt;
		int                best;
		int                i;
		int                j;
		payout_t           run [NOTES];
		case (rq.op)
			OP_APPEND: begin
				if (rq.dv != '0 && note_fill < NOTES) begin
					note_tbl[note_fill] = rq.dv;
					note_fill++;
				end
			end
			OP_CLEAR: begin
				note_fill = 0;
			end
			OP_WITHDRAW: begin
				rest = rq.amt;
				for (i = 0; i + 1 < note_fill; i++) begin
					best = i;
					for (j = i + 1; j < note_fill; j++) begin
						if (note_tbl[j] > note_tbl[best])
							best = j;
					end
					tmp            = note_tbl[best];
					note_tbl[best] = note_tbl[i];
					note_tbl[i]    = tmp;
				end
				for (i = 0; i < note_fill; i++) begin
					cnt = '0;
					if (note_tbl[i] != '0 && rest >= note_tbl[i]) begin
						cnt  = rest / note_tbl[i];
						rest = rest - cnt * note_tbl[i];
					end
					run[i].denom = note_tbl[i];
					run[i].count = cnt;
				end
				if (rq.fixed) begin
					payout_q.push_back('{rq.w_denom, rq.w_count, rq.w_rem, rq.w_exact,
						rq.w_last});
				end else if (note_fill == 0) begin
					payout_q.push_back('{'0, '0, rest, rest == '0, 1'b1});
				end else begin
					for (i = 0; i < note_fill; i++) begin
						run[i].rem   = rest;
						run[i].exact = (rest == '0);
						run[i].last  = (i == note_fill - 1);
						payout_q.push_back(run[i]);
					end
				end
			end
			default: ;
		endcase
	endtask

	task automatic queue_request(input logic [OP_W-1:0] o, input logic [DATA_W-1:0] d,
		input logic [DATA_W-1:0] a);
		request_t rq;
		rq     = '0;
		rq.op  = o;
		rq.dv  = d;
		rq.amt = a;
		request_q.push_back(rq);
		if (o != OP_UNUSED && !(o == OP_APPEND && d == '0))
			useful_cnt++;
	endtask

	// sender: bursts of items with random gaps between them
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid    <= 1'b0;
			op          <= OP_APPEND;
			denom_value <= '0;
			amount      <= '0;
			send_idx    <= 0;
			burst_left  <= 0;
			gap_left    <= 0;
		end else begin
			next_idx = send_idx;
			if (in_valid && in_ready) begin
				predict_payout(request_q[send_idx]);
				next_idx = send_idx + 1;
			end
			send_idx <= next_idx;
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					in_valid <= 1'b0;
					gap_left <= gap_left - 1;
				end else if (next_idx < request_q.size()) begin
					in_valid    <= 1'b1;
					op          <= request_q[next_idx].op;
					denom_value <= request_q[next_idx].dv;
					amount      <= request_q[next_idx].amt;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 16);
						if ($urandom_range(0, 2) == 0)
							gap_left <= 0;
						else
							gap_left <= $urandom_range(1, 6);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver: epochs of always ready, coin-flip ready, or stall runs
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready  <= 1'b0;
			stall_left <= 0;
			rx_mode    <= 0;
			rx_epoch   <= 0;
		end else begin
			if (rx_epoch == 0) begin
				rx_mode  <= $urandom_range(0, 2);
				rx_epoch <= $urandom_range(50, 400);
			end else begin
				rx_epoch <= rx_epoch - 1;
			end
			if (stall_left > 0) begin
				out_ready  <= 1'b0;
				stall_left <= stall_left - 1;
			end else if (rx_mode == 0) begin
				out_ready <= 1'b1;
			end else if (rx_mode == 1) begin
				out_ready <= 1'($urandom_range(0, 1));
			end else begin
				out_ready <= 1'b1;
				if ($urandom_range(0, 5) == 0)
					stall_left <= $urandom_range(1, 8);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			got = '{denomination, note_count, remainder, exact, last};
			if (payout_q.size() == 0) begin
				err_cnt++;
				if (err_cnt <= MAX_REPORTS)
					$display("unexpected item: denom %h count %h rem %h exact %b last %b",
						got.denom, got.count, got.rem, got.exact, got.last);
			end else begin
				want = payout_q.pop_front();
				if (got.denom !== want.denom || got.count !== want.count ||
					got.rem !== want.rem || got.exact !== want.exact ||
					got.last !== want.last) begin
					err_cnt++;
					if (err_cnt <= MAX_REPORTS) begin
						$display("mismatch: expected denom %h count %h rem %h exact %b last %b",
							want.denom, want.count, want.rem, want.exact, want.last);
						$display("          actual   denom %h count %h rem %h exact %b last %b",
							got.denom, got.count, got.rem, got.exact, got.last);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("FAIL greedy_change_dispenser_unit");
			$finish;
		end
	end

	initial begin
		int                style;
		int                n;
		int                k;
		logic [DATA_W-1:0] note;
		logic [DATA_W-1:0] amt;
		foreach (DIRECTED[i])
			request_q.push_back(DIRECTED[i]);
		useful_cnt = $size(DIRECTED);
		while (useful_cnt < ITEM_TARGET) begin
			if ($urandom_range(0, 9) == 0) begin
				case ($urandom_range(0, 2))
					0: queue_request(OP_UNUSED, $urandom, $urandom);
					1: queue_request(OP_APPEND, '0, $urandom);
					default: queue_request(OP_WITHDRAW, $urandom, $urandom);
				endcase
			end else begin
				if ($urandom_range(0, 2) != 0)
					queue_request(OP_CLEAR, $urandom, $urandom);
				style = $urandom_range(0, 3);
				if ($urandom_range(0, 11) == 0)
					n = $urandom_range(28, 40);
				else
					n = $urandom_range(0, 6);
				for (int i = 0; i < n; i++) begin
					case (style)
						0: note = $urandom_range(1, 10);
						1: note = $urandom_range(1, 1000);
						2: note = $urandom;
						default: note = 32'd1 << $urandom_range(0, 31);
					endcase
					if ($urandom_range(0, 15) == 0)
						note = '0;
					queue_request(OP_APPEND, note, $urandom);
				end
				k = $urandom_range(1, 3);
				for (int j = 0; j < k; j++) begin
					case ($urandom_range(0, 3))
						0: amt = $urandom_range(0, 100);
						1: amt = $urandom;
						2: amt = 32'hFFFF_FFFF - $urandom_range(0, 3);
						default: amt = $urandom_range(0, 100000);
					endcase
					queue_request(OP_WITHDRAW, $urandom, amt);
				end
			end
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		while (send_idx < request_q.size() || payout_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_cnt == 0)
			$display("PASS greedy_change_dispenser_unit");
		else
			$display("FAIL greedy_change_dispenser_unit");
		$finish;
	end
endmodule
